FILE: rtl/core/ids_pkg.sv
// Shared widths, constants and beat types of the image difference statistics block.
package ids_pkg;

	localparam int unsigned CH_W     = 16;
	localparam int unsigned TOL_W    = 14;
	localparam int unsigned CNT_W    = 24;
	localparam int unsigned SUM_W    = 40;
	localparam int unsigned SQ_W     = 56;

	// Per-pixel partial widths: three channels summed, three squares summed.
	localparam int unsigned CH_SUM_W = CH_W + 2;
	localparam int unsigned SQ_ITEM_W = 2 * CH_W + 2;
	// |d|*200 needs eight more bits than a channel.
	localparam int unsigned REL_W    = CH_W + 8;
	localparam int unsigned PROD_W   = SUM_W + TOL_W;

	localparam int unsigned SMALL_SCALE   = 200;
	localparam int unsigned BIG_SCALE     = 20;
	localparam int unsigned VERDICT_SCALE = 10000;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		chan_t ref_red;
		chan_t ref_green;
		chan_t ref_blue;
		chan_t test_red;
		chan_t test_green;
		chan_t test_blue;
		logic  last_pixel;
	} pixel_t;

	typedef struct packed {
		chan_t              diff_red;
		chan_t              diff_green;
		chan_t              diff_blue;
		logic [CNT_W-1:0]   small_count;
		logic [CNT_W-1:0]   big_count;
		logic [SUM_W-1:0]   ref_total;
		logic [SUM_W-1:0]   test_total;
		logic [SQ_W-1:0]    squared_error_total;
		logic               images_differ;
		logic               totals_valid;
	} result_t;

	// One classified pixel, as queued between front and back.
	typedef struct packed {
		chan_t                 diff_red;
		chan_t                 diff_green;
		chan_t                 diff_blue;
		logic [SQ_ITEM_W-1:0]  sq_sum;
		logic [1:0]            small_cnt;
		logic [1:0]            big_cnt;
		logic [CH_SUM_W-1:0]   ref_sum;
		logic [CH_SUM_W-1:0]   test_sum;
		logic                  last;
	} entry_t;

endpackage

FILE: rtl/core/ids_if.sv
// Valid/ready channel interfaces of the image difference statistics block.
interface ids_pixel_if import ids_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ids_result_if import ids_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ids_cfg_if import ids_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TOL_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ids_entry_if import ids_pkg::*; ();
	logic   valid;
	logic   ready;
	entry_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/image_difference_statistics.sv
// Top level of the image difference statistics block.
//
// Usage: stream one pixel beat per cycle on "pixel" (reference and test
// channels, unsigned Q8.8, plus last_pixel). Every pixel beat yields one beat
// on "result" with the per-channel absolute differences. The beat of the
// pixel marked last also carries the image totals (channel sums, squared
// error, error counters) and the verdict, with totals_valid set; the
// statistics are then cleared for the next image.
// "cfg" writes the tolerance in hundredths of a percent; write it only while
// no pixel is in flight. Zero selects the strict test.
// A pixel beat passes the front register, a queue slot and four back-end stages
// on its way to its result beat.
// Throughput: one pixel per cycle unless "result" stalls, set by the single
// saturating add per back-end accumulator; every stage is one register deep.
// The front end (difference, square, relative tests) feeds a short queue,
// so a stall on "result" first fills the back-end stages and the queue and
// only then drops pixel.ready.
// Reset (arst_n low): all beats in flight are dropped, statistics and the
// tolerance return to zero.
module image_difference_statistics import ids_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	ids_pixel_if.sink pixel,
	ids_result_if.source result,
	ids_cfg_if.sink cfg
);

	logic [TOL_W-1:0] tol_q;

	ids_entry_if front_to_queue ();
	ids_entry_if queue_to_back ();

	// Hold the tolerance; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg.valid) begin
			tol_q <= cfg.data;
		end
	end

	// Classify each pixel: differences, squares, small/big error classes.
	ids_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.entry  (front_to_queue.source)
	);

	// Decouple the two halves so each may stall on its own.
	ids_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_to_queue.sink),
		.pop    (queue_to_back.source)
	);

	// Accumulate, close the image, advance the verdict to the output register.
	ids_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.tol    (tol_q),
		.entry  (queue_to_back.sink),
		.result (result)
	);

endmodule

FILE: rtl/core/ids_front.sv
// Front end: takes pixel beats, forms differences, squares and error classes.
module ids_front import ids_pkg::*; (
	input logic clk,
	input logic arst_n,
	ids_pixel_if.sink pixel,
	ids_entry_if.source entry
);

	logic              fa_v_s1;
	chan_t [2:0]       diff_s1;
	chan_t [2:0]       ref_s1;
	chan_t [2:0]       test_s1;
	logic              last_s1;

	chan_t [2:0]       ref_in;
	chan_t [2:0]       test_in;
	chan_t [2:0]       diff_in;
	logic [2:0][2*CH_W-1:0] sq;
	logic [2:0]        small_f;
	logic [2:0]        big_f;
	logic              accept;

	assign pixel.ready = !fa_v_s1 || entry.ready;
	assign accept      = pixel.valid && pixel.ready;

	always_comb begin
		ref_in[0]  = pixel.data.ref_red;
		ref_in[1]  = pixel.data.ref_green;
		ref_in[2]  = pixel.data.ref_blue;
		test_in[0] = pixel.data.test_red;
		test_in[1] = pixel.data.test_green;
		test_in[2] = pixel.data.test_blue;
		for (int k = 0; k < 3; k++) begin
			diff_in[k] = (ref_in[k] > test_in[k]) ? (ref_in[k] - test_in[k])
				: (test_in[k] - ref_in[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_v_s1 <= 1'b0;
		end else if (accept) begin
			fa_v_s1 <= 1'b1;
		end else if (entry.ready) begin
			fa_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_s1 <= diff_in;
			ref_s1  <= ref_in;
			test_s1 <= test_in;
			last_s1 <= pixel.data.last_pixel;
		end
	end

	// A channel with both values zero gives zero difference and fails both
	// relative tests, so it drops out of every sum without a flag of its own.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sq[k]      = {{CH_W{1'b0}}, diff_s1[k]} * {{CH_W{1'b0}}, diff_s1[k]};
			small_f[k] = (REL_W'(diff_s1[k]) * REL_W'(SMALL_SCALE)) > REL_W'(ref_s1[k]);
			big_f[k]   = (REL_W'(diff_s1[k]) * REL_W'(BIG_SCALE)) > REL_W'(ref_s1[k]);
		end
	end

	assign entry.valid = fa_v_s1;

	always_comb begin
		entry.data.diff_red   = diff_s1[0];
		entry.data.diff_green = diff_s1[1];
		entry.data.diff_blue  = diff_s1[2];
		entry.data.sq_sum     = SQ_ITEM_W'(sq[0]) + SQ_ITEM_W'(sq[1]) + SQ_ITEM_W'(sq[2]);
		entry.data.small_cnt  = {1'b0, small_f[0]} + {1'b0, small_f[1]} + {1'b0, small_f[2]};
		entry.data.big_cnt    = {1'b0, big_f[0]} + {1'b0, big_f[1]} + {1'b0, big_f[2]};
		entry.data.ref_sum    = CH_SUM_W'(ref_s1[0]) + CH_SUM_W'(ref_s1[1])
			+ CH_SUM_W'(ref_s1[2]);
		entry.data.test_sum   = CH_SUM_W'(test_s1[0]) + CH_SUM_W'(test_s1[1])
			+ CH_SUM_W'(test_s1[2]);
		entry.data.last       = last_s1;
	end

endmodule

FILE: rtl/core/ids_queue.sv
// Short queue of classified pixels between the front and back ends.
module ids_queue import ids_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	ids_entry_if.sink push,
	ids_entry_if.source pop
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [IDX_W-1:0]  wr_ptr_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push.ready = (count_q != CNT_QW'(DEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.data   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue fill count missed a pop");

endmodule

FILE: rtl/core/ids_back.sv
// Back end: accumulates statistics, closes an image on its last pixel, forms the verdict.
module ids_back import ids_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [TOL_W-1:0] tol,
	ids_entry_if.sink entry,
	ids_result_if.source result
);

	typedef struct packed {
		chan_t            diff_red;
		chan_t            diff_green;
		chan_t            diff_blue;
		logic             last;
		logic [CNT_W-1:0] small_tot;
		logic [CNT_W-1:0] big_tot;
		logic [SUM_W-1:0] ref_tot;
		logic [SUM_W-1:0] test_tot;
		logic [SQ_W-1:0]  sq_tot;
	} tot_t;

	logic [SUM_W-1:0] ref_acc_q;
	logic [SUM_W-1:0] test_acc_q;
	logic [SQ_W-1:0]  sq_acc_q;
	logic [CNT_W-1:0] small_q;
	logic [CNT_W-1:0] big_q;

	logic              v_s1, v_s2, v_s3, v_s4;
	tot_t              tot_s1, tot_s2, tot_s3;
	logic [SUM_W-1:0]  delta_s2, lo_s2;
	logic [PROD_W-1:0] pa_s3, pb_s3;
	logic              strict_s3;
	result_t           res_s4;

	logic [SUM_W:0]   ref_nx, test_nx;
	logic [SQ_W:0]    sq_nx;
	logic [CNT_W:0]   small_nx, big_nx;
	logic [SUM_W-1:0] ref_sat, test_sat;
	logic [SQ_W-1:0]  sq_sat;
	logic [CNT_W-1:0] small_sat, big_sat;
	logic             out_free, s3_free, s2_free, s1_free, do_pop;

	assign out_free    = !v_s4 || result.ready;
	assign s3_free     = !v_s3 || out_free;
	assign s2_free     = !v_s2 || s3_free;
	assign s1_free     = !v_s1 || s2_free;
	assign entry.ready = s1_free;
	assign do_pop      = entry.valid && s1_free;

	// Accumulators never exceed their maximum, so a carry out means saturate.
	always_comb begin
		ref_nx    = {1'b0, ref_acc_q} + (SUM_W+1)'(entry.data.ref_sum);
		test_nx   = {1'b0, test_acc_q} + (SUM_W+1)'(entry.data.test_sum);
		sq_nx     = {1'b0, sq_acc_q} + (SQ_W+1)'(entry.data.sq_sum);
		small_nx  = {1'b0, small_q} + (CNT_W+1)'(entry.data.small_cnt);
		big_nx    = {1'b0, big_q} + (CNT_W+1)'(entry.data.big_cnt);
		ref_sat   = ref_nx[SUM_W] ? '1 : ref_nx[SUM_W-1:0];
		test_sat  = test_nx[SUM_W] ? '1 : test_nx[SUM_W-1:0];
		sq_sat    = sq_nx[SQ_W] ? '1 : sq_nx[SQ_W-1:0];
		small_sat = small_nx[CNT_W] ? '1 : small_nx[CNT_W-1:0];
		big_sat   = big_nx[CNT_W] ? '1 : big_nx[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_acc_q  <= '0;
			test_acc_q <= '0;
			sq_acc_q   <= '0;
			small_q    <= '0;
			big_q      <= '0;
		end else if (do_pop) begin
			if (entry.data.last) begin
				ref_acc_q  <= '0;
				test_acc_q <= '0;
				sq_acc_q   <= '0;
				small_q    <= '0;
				big_q      <= '0;
			end else begin
				ref_acc_q  <= ref_sat;
				test_acc_q <= test_sat;
				sq_acc_q   <= sq_sat;
				small_q    <= small_sat;
				big_q      <= big_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= do_pop;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (s3_free) begin
				v_s3 <= v_s2;
			end
			if (out_free) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1: snapshot the closed totals; mid-image beats carry zeros.
	always_ff @(posedge clk) begin
		if (do_pop) begin
			tot_s1.diff_red   <= entry.data.diff_red;
			tot_s1.diff_green <= entry.data.diff_green;
			tot_s1.diff_blue  <= entry.data.diff_blue;
			tot_s1.last       <= entry.data.last;
			tot_s1.small_tot  <= entry.data.last ? small_sat : '0;
			tot_s1.big_tot    <= entry.data.last ? big_sat : '0;
			tot_s1.ref_tot    <= entry.data.last ? ref_sat : '0;
			tot_s1.test_tot   <= entry.data.last ? test_sat : '0;
			tot_s1.sq_tot     <= entry.data.last ? sq_sat : '0;
		end
	end

	// Stage 2: distance and minimum of the two totals.
	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			tot_s2   <= tot_s1;
			delta_s2 <= (tot_s1.ref_tot > tot_s1.test_tot)
				? (tot_s1.ref_tot - tot_s1.test_tot) : (tot_s1.test_tot - tot_s1.ref_tot);
			lo_s2    <= (tot_s1.ref_tot < tot_s1.test_tot) ? tot_s1.ref_tot : tot_s1.test_tot;
		end
	end

	// Stage 3: both sides of the tolerance test and the strict-mode flag.
	always_ff @(posedge clk) begin
		if (s3_free && v_s2) begin
			tot_s3    <= tot_s2;
			pa_s3     <= PROD_W'(delta_s2) * PROD_W'(VERDICT_SCALE);
			pb_s3     <= PROD_W'(lo_s2) * PROD_W'(tol);
			strict_s3 <= (tot_s2.small_tot != '0) || (tot_s2.big_tot != '0);
		end
	end

	// Stage 4: output register.
	always_ff @(posedge clk) begin
		if (out_free && v_s3) begin
			res_s4.diff_red            <= tot_s3.diff_red;
			res_s4.diff_green          <= tot_s3.diff_green;
			res_s4.diff_blue           <= tot_s3.diff_blue;
			res_s4.small_count         <= tot_s3.small_tot;
			res_s4.big_count           <= tot_s3.big_tot;
			res_s4.ref_total           <= tot_s3.ref_tot;
			res_s4.test_total          <= tot_s3.test_tot;
			res_s4.squared_error_total <= tot_s3.sq_tot;
			res_s4.images_differ       <= tot_s3.last
				&& ((tol == '0) ? strict_s3 : (pa_s3 > pb_s3));
			res_s4.totals_valid        <= tot_s3.last;
		end
	end

	assign result.valid = v_s4;
	assign result.data  = res_s4;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && entry.data.last) |=> (ref_acc_q == '0 && test_acc_q == '0
			&& sq_acc_q == '0 && small_q == '0 && big_q == '0))
		else $error("statistics not cleared after last pixel");

	a_mid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.data.totals_valid) |-> (result.data.ref_total == '0
			&& result.data.squared_error_total == '0 && !result.data.images_differ))
		else $error("mid-image result carries totals");

	a_strict_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.totals_valid && tol == '0) |->
			(result.data.images_differ == ((result.data.small_count != '0)
				|| (result.data.big_count != '0))))
		else $error("strict verdict disagrees with counters");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the image difference statistics block.
module tb import ids_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Run-wide bounds. Leave a margin after the last result before
	// reprogramming the tolerance or declaring the run over.
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned STALL_CYCLES = 400;

	localparam logic [63:0] SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
	localparam logic [63:0] SQ_LIMIT    = (64'd1 << SQ_W) - 64'd1;
	localparam logic [63:0] COUNT_LIMIT = (64'd1 << CNT_W) - 64'd1;

	logic clk;
	logic arst_n;

	ids_pixel_if  pix ();
	ids_result_if res ();
	ids_cfg_if    cfg_ch ();

	image_difference_statistics dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix),
		.result (res),
		.cfg    (cfg_ch)
	);

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle rates in percent, set per phase by the test sequence.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	// A long result stall is requested here and counted down by the ready driver.
	int unsigned stall_request = 0;
	int unsigned stall_left    = 0;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	// Predicted statistics of the image in progress, kept 64 bits wide so that
	// the saturation tests never wrap.
	logic [63:0]      ref_sum_acc;
	logic [63:0]      test_sum_acc;
	logic [63:0]      small_tally;
	logic [63:0]      big_tally;
	logic [63:0]      sq_err_acc;
	logic [TOL_W-1:0] tolerance_reg;

	// Result beats predicted but not yet seen, oldest first.
	result_t expected_results[$];

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] inc,
		logic [63:0] limit);
		if (acc >= limit || inc > limit - acc)
			return limit;
		return acc + inc;
	endfunction

	// Return |r - t| and fold the channel into the running statistics. A channel
	// where both values are zero leaves every sum and counter untouched.
	function automatic chan_t accumulate_channel(chan_t r, chan_t t);
		logic [63:0] d;
		logic [63:0] rw;
		logic [63:0] tw;
		rw = {48'b0, r};
		tw = {48'b0, t};
		d = (r > t) ? {48'b0, r - t} : {48'b0, t - r};
		if (r == '0 && t == '0)
			return '0;
		ref_sum_acc  = sat_add(ref_sum_acc, rw, SUM_LIMIT);
		test_sum_acc = sat_add(test_sum_acc, tw, SUM_LIMIT);
		sq_err_acc   = sat_add(sq_err_acc, d * d, SQ_LIMIT);
		// Relative tests by multiplication; a zero reference counts as infinite error.
		if (d * SMALL_SCALE > rw)
			small_tally = sat_add(small_tally, 64'd1, COUNT_LIMIT);
		if (d * BIG_SCALE > rw)
			big_tally = sat_add(big_tally, 64'd1, COUNT_LIMIT);
		return d[CH_W-1:0];
	endfunction

	function automatic void clear_statistics();
		ref_sum_acc  = '0;
		test_sum_acc = '0;
		small_tally  = '0;
		big_tally    = '0;
		sq_err_acc   = '0;
	endfunction

	function automatic result_t predict_pixel(pixel_t p);
		result_t     r;
		logic [63:0] delta;
		logic [63:0] lo;
		logic        differ;
		r = '0;
		r.diff_red   = accumulate_channel(p.ref_red, p.test_red);
		r.diff_green = accumulate_channel(p.ref_green, p.test_green);
		r.diff_blue  = accumulate_channel(p.ref_blue, p.test_blue);
		if (p.last_pixel) begin
			delta = (ref_sum_acc > test_sum_acc) ? ref_sum_acc - test_sum_acc
				: test_sum_acc - ref_sum_acc;
			lo = (ref_sum_acc < test_sum_acc) ? ref_sum_acc : test_sum_acc;
			// Strict mode: any flagged channel fails. Otherwise compare the totals.
			if (tolerance_reg == '0)
				differ = (small_tally != 0) || (big_tally != 0);
			else
				differ = (delta * VERDICT_SCALE) > ({50'b0, tolerance_reg} * lo);
			r.small_count         = small_tally[CNT_W-1:0];
			r.big_count           = big_tally[CNT_W-1:0];
			r.ref_total           = ref_sum_acc[SUM_W-1:0];
			r.test_total          = test_sum_acc[SUM_W-1:0];
			r.squared_error_total = sq_err_acc[SQ_W-1:0];
			r.images_differ       = differ;
			r.totals_valid        = 1'b1;
			clear_statistics();
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: predict on every pixel beat, compare on every result beat.
	// One process handles both so that predicting and comparing run in a fixed order.
	// ------------------------------------------------------------------

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name,
					want, got);
		end
	endfunction

	function automatic void compare_result(result_t want, result_t got);
		check_field("diff_red", 64'(want.diff_red), 64'(got.diff_red));
		check_field("diff_green", 64'(want.diff_green), 64'(got.diff_green));
		check_field("diff_blue", 64'(want.diff_blue), 64'(got.diff_blue));
		check_field("small_count", 64'(want.small_count), 64'(got.small_count));
		check_field("big_count", 64'(want.big_count), 64'(got.big_count));
		check_field("ref_total", 64'(want.ref_total), 64'(got.ref_total));
		check_field("test_total", 64'(want.test_total), 64'(got.test_total));
		check_field("squared_error_total", 64'(want.squared_error_total),
			64'(got.squared_error_total));
		check_field("images_differ", 64'(want.images_differ), 64'(got.images_differ));
		check_field("totals_valid", 64'(want.totals_valid), 64'(got.totals_valid));
	endfunction

	initial begin
		clear_statistics();
		tolerance_reg = '0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				tolerance_reg = cfg_ch.data;
			if (pix.valid && pix.ready)
				expected_results.insert(expected_results.size(), predict_pixel(pix.data));
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result beat with nothing expected", $realtime);
				end else begin
					compare_result(expected_results.pop_front(), res.data);
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("image_difference_statistics regression: fail");
			$finish;
		end
	end

	// Result ready: a requested long stall takes priority over random idling.
	always @(negedge clk) begin
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic pixel_t make_pixel(int unsigned rr, int unsigned rg, int unsigned rb,
		int unsigned tr, int unsigned tg, int unsigned tb_, bit last);
		pixel_t p;
		p.ref_red    = rr[CH_W-1:0];
		p.ref_green  = rg[CH_W-1:0];
		p.ref_blue   = rb[CH_W-1:0];
		p.test_red   = tr[CH_W-1:0];
		p.test_green = tg[CH_W-1:0];
		p.test_blue  = tb_[CH_W-1:0];
		p.last_pixel = last;
		return p;
	endfunction

	// Offer one pixel beat after a random gap; return at the edge that takes it.
	task automatic send_pixel(pixel_t p);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.data  <= p;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
	endtask

	// Drop valid, wait for every predicted result, then let the pipe settle.
	task automatic wait_drained();
		@(negedge clk);
		pix.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [TOL_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// One reference/test channel pair, weighted towards near-equal values so that
	// the counters and the tolerance verdict go both ways.
	task automatic random_channel(output int unsigned r, output int unsigned t);
		int rv;
		int tv;
		int span;
		rv = int'($urandom_range(65535));
		case ($urandom_range(9))
			0: begin
				rv = 0;
				tv = 0;
			end
			1: begin
				rv = 0;
				tv = int'($urandom_range(65535));
			end
			2: tv = 0;
			3, 4: tv = int'($urandom_range(65535));
			9: begin
				rv = 65535;
				tv = $urandom_range(1) ? 65535 : int'($urandom_range(65535));
			end
			default: begin
				span = (rv >> $urandom_range(3, 10)) + 1;
				tv = rv + int'($urandom_range(2 * span)) - span;
				if (tv < 0)
					tv = 0;
				if (tv > 65535)
					tv = 65535;
			end
		endcase
		r = rv;
		t = tv;
	endtask

	task automatic send_random_image(int unsigned n_pixels);
		int unsigned rr, rg, rb, tr, tg, tbl;
		for (int unsigned i = 0; i < n_pixels; i++) begin
			random_channel(rr, tr);
			random_channel(rg, tg);
			random_channel(rb, tbl);
			send_pixel(make_pixel(rr, rg, rb, tr, tg, tbl, i == n_pixels - 1));
		end
	endtask

	// Mostly short images, now and then a long one.
	function automatic int unsigned random_image_length();
		if ($urandom_range(19) == 0)
			return $urandom_range(50, 200);
		return $urandom_range(1, 12);
	endfunction

	function automatic logic [TOL_W-1:0] random_tolerance();
		case ($urandom_range(6))
			0: return '0;
			1: return 14'd1;
			2: return 14'd10000;
			3: return '1;
			default: return 14'($urandom_range(1, 600));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Strict tolerance: skipped zero channels, infinite error, extremes and the
	// exact boundaries of both relative tests.
	task automatic test_strict_verdict();
		wait_drained();
		write_tolerance('0);
		// image of nothing but zero channels: all totals zero, images equal
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 1'b1));
		// identical full-scale image
		send_pixel(make_pixel(65535, 65535, 65535, 65535, 65535, 65535, 1'b1));
		// zero reference against full-scale test
		send_pixel(make_pixel(0, 0, 0, 65535, 0, 0, 1'b1));
		// extremes both ways, then boundary pairs for the half-percent test
		send_pixel(make_pixel(65535, 0, 1, 0, 65535, 1, 1'b0));
		send_pixel(make_pixel(200, 199, 20, 201, 200, 21, 1'b0));
		// boundary pairs for the five-percent test
		send_pixel(make_pixel(19, 21, 65535, 20, 20, 65534, 1'b1));
		// a tenth of a percent, below both thresholds: nothing counted, images equal
		send_pixel(make_pixel(1000, 0, 0, 1001, 0, 0, 1'b1));
		// exactly on the half-percent boundary in both channels: nothing counted, images equal
		send_pixel(make_pixel(200, 400, 0, 201, 402, 0, 1'b1));
	endtask

	// Nonzero tolerances around the verdict threshold, low test totals and
	// a zero-total image.
	task automatic test_tolerance_verdict();
		wait_drained();
		write_tolerance(14'd1);
		send_pixel(make_pixel(10000, 0, 0, 10001, 0, 0, 1'b1));
		send_pixel(make_pixel(10000, 0, 0, 10002, 0, 0, 1'b1));
		send_pixel(make_pixel(10002, 0, 0, 10000, 0, 0, 1'b1));
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 1'b1));
		wait_drained();
		write_tolerance(14'd10000);
		send_pixel(make_pixel(10000, 0, 0, 20000, 0, 0, 1'b1));
		send_pixel(make_pixel(5000, 5000, 0, 10000, 10001, 0, 1'b1));
		wait_drained();
		write_tolerance('1);
		send_pixel(make_pixel(100, 0, 0, 200, 0, 0, 1'b1));
		send_pixel(make_pixel(65535, 0, 0, 0, 0, 0, 1'b1));
	endtask

	// Several tolerance settings, each with a run of random images.
	task automatic test_random_images(int unsigned send_pct, int unsigned recv_pct,
		int unsigned pixels_wanted);
		int unsigned sent;
		int unsigned len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int s = 0; s < 4; s++) begin
			wait_drained();
			write_tolerance(random_tolerance());
			sent = 0;
			while (sent < pixels_wanted / 4) begin
				len = random_image_length();
				send_random_image(len);
				sent += len;
			end
		end
	endtask

	// Hold result ready low for a long stretch while pixels keep coming, so the
	// queue fills and the block refuses pixel beats.
	task automatic test_result_backpressure();
		wait_drained();
		write_tolerance(14'd50);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		stall_request = STALL_CYCLES;
		send_random_image(30);
		send_random_image(30);
	endtask

	initial begin
		arst_n       = 1'b0;
		pix.valid    = 1'b0;
		pix.data     = '0;
		res.ready    = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_strict_verdict();
		test_tolerance_verdict();
		test_result_backpressure();
		test_random_images(6, 51, 540);
		test_random_images(51, 6, 540);
		test_random_images(0, 0, 540);

		wait_drained();
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("image_difference_statistics regression: pass");
		end else begin
			$display("image_difference_statistics regression: fail");
		end
		$finish;
	end

endmodule
